@@ rtl/km2midi_pkg.sv @@
// ============================================================================
// km2midi_pkg: shared types and constants for the key matrix MIDI block
// Holds the keymap ROM, action codes, MIDI status nibbles, register indexes
// and the structs passed between the top level and the event logic.
// ============================================================================
package km2midi_pkg;

  // Matrix geometry and derived widths.
  localparam int ROWS       = 6;
  localparam int COLS       = 7;
  localparam int KEYS       = ROWS * COLS;
  localparam int KEY_IDX_W  = $clog2(KEYS);
  localparam int NOTE_LIMIT = 42;
  localparam int OCT_MAX    = 4;

  // Keymap action codes. Non-negative codes are note numbers.
  localparam logic signed [7:0] CODE_EMPTY    = -8'sd5;
  localparam logic signed [7:0] CODE_ENC_SW_A = -8'sd1;
  localparam logic signed [7:0] CODE_ENC_SW_B = -8'sd2;
  localparam logic signed [7:0] CODE_OCT_UP   = -8'sd3;
  localparam logic signed [7:0] CODE_OCT_DOWN = -8'sd4;
  localparam logic signed [7:0] CODE_CC_BASE  = -8'sd30;

  // Controller numbers for the encoder switches and encoder turns.
  localparam logic [6:0] CC_ENC_SW_A = 7'd20;
  localparam logic [6:0] CC_ENC_SW_B = 7'd21;
  localparam logic [6:0] CC_ENC_TURN = 7'd22;
  localparam logic [6:0] REL_UP      = 7'd1;
  localparam logic [6:0] REL_DOWN    = 7'd127;

  // MIDI status high nibbles.
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CC       = 4'hB;

  // Input item kinds.
  localparam logic KIND_KEY     = 1'b0;
  localparam logic KIND_ENCODER = 1'b1;

  // Keymap ROM, row-major, one entry per matrix position.
  localparam logic signed [7:0] KEY_MAP [KEYS] = '{
    8'sd49,  8'sd51,  CODE_EMPTY, 8'sd54,  8'sd56,  8'sd58,  CODE_EMPTY,
    8'sd48,  8'sd50,  8'sd52,  8'sd53,  8'sd55,  8'sd57,  8'sd59,
    8'sd61,  8'sd63,  CODE_EMPTY, 8'sd66,  8'sd68,  8'sd70,  CODE_EMPTY,
    8'sd60,  8'sd62,  8'sd64,  8'sd65,  8'sd67,  8'sd69,  8'sd71,
    -8'sd30, -8'sd31, -8'sd32, -8'sd33, CODE_OCT_UP,   CODE_EMPTY, CODE_ENC_SW_A,
    -8'sd35, -8'sd36, -8'sd37, -8'sd38, CODE_OCT_DOWN, CODE_EMPTY, CODE_ENC_SW_B
  };

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CHANNEL      = 2'd0,
    CFG_OCTAVE_LIMIT = 2'd1,
    CFG_PRESS_VALUE  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [4:0] channel;
    logic [2:0] octave_limit;
    logic [6:0] press_value;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [2:0]         key_row;
    logic [2:0]         key_col;
    logic               key_down;
    logic               encoder_select;
    logic signed [15:0] encoder_position;
  } item_t;

  typedef struct packed {
    logic signed [3:0] shift_octaves;
    logic [5:0]        held_notes;
    logic signed [15:0] enc_pos0;
    logic signed [15:0] enc_pos1;
  } state_t;

  typedef struct packed {
    logic              msg_valid;
    logic [7:0]        status_byte;
    logic [6:0]        data_one;
    logic [6:0]        data_two;
    logic signed [3:0] octave_shift;
    logic [5:0]        active_notes;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [KEY_IDX_W-1:0] idx;
    logic                 val;
  } latch_upd_t;

endpackage

@@ rtl/km2midi_event.sv @@
// ============================================================================
// km2midi_event: per-item event logic
// Given one item, the latched key states, the running state and the
// configuration, computes the result item, the next state and the key
// latch update. Purely combinational; the caller registers everything.
// ============================================================================
module km2midi_event (
  input  km2midi_pkg::item_t              item,
  input  km2midi_pkg::cfg_t               cfg,
  input  km2midi_pkg::state_t             state,
  input  logic [km2midi_pkg::KEYS-1:0]    key_latch,
  output km2midi_pkg::result_t            res,
  output km2midi_pkg::state_t             state_next,
  output km2midi_pkg::latch_upd_t         upd
);
  import km2midi_pkg::*;

  logic [2:0]           lim;
  logic signed [4:0]    lim_s;
  logic signed [4:0]    shift_s;
  logic [KEY_IDX_W-1:0] idx;
  logic                 in_range;
  logic                 changed;
  logic signed [7:0]    code;
  logic [6:0]           pv;
  logic signed [7:0]    shift8;
  logic [7:0]           note8;
  logic [3:0]           ch_nib;
  logic signed [15:0]   last_pos;

  // Clamp the limit, locate the key and read its keymap entry.
  always_comb begin
    lim      = (cfg.octave_limit > 3'(OCT_MAX)) ? 3'(OCT_MAX) : cfg.octave_limit;
    lim_s    = $signed({2'b00, lim});
    shift_s  = {state.shift_octaves[3], state.shift_octaves};
    in_range = (int'(item.key_row) < ROWS) && (int'(item.key_col) < COLS);
    idx      = KEY_IDX_W'(item.key_row) * KEY_IDX_W'(COLS) + KEY_IDX_W'(item.key_col);
    code     = in_range ? KEY_MAP[idx] : CODE_EMPTY;
    changed  = (item.kind == KIND_KEY) && in_range && (key_latch[idx] != item.key_down);
    pv       = item.key_down ? cfg.press_value : 7'd0;
    // Note number with the octave shift: shift * 12 as (shift << 3) + (shift << 2).
    shift8   = 8'(state.shift_octaves);
    note8    = 8'(code) + 8'(shift8 <<< 3) + 8'(shift8 <<< 2);
    ch_nib   = 4'(cfg.channel) - 4'd1;
    last_pos = item.encoder_select ? state.enc_pos1 : state.enc_pos0;
  end

  // Decide the message and the state changes.
  always_comb begin
    res.msg_valid   = 1'b0;
    res.status_byte = 8'd0;
    res.data_one    = 7'd0;
    res.data_two    = 7'd0;
    state_next      = state;
    upd.we          = 1'b0;
    upd.idx         = idx;
    upd.val         = item.key_down;

    if (item.kind == KIND_KEY) begin
      if (changed) begin
        upd.we = 1'b1;
        if (code >= 8'sd0) begin
          // Note key: note-on or note-off, held count saturates.
          res.msg_valid   = 1'b1;
          res.status_byte = {item.key_down ? ST_NOTE_ON : ST_NOTE_OFF, ch_nib};
          res.data_one    = note8[6:0];
          res.data_two    = pv;
          if (item.key_down) begin
            if (int'(state.held_notes) < NOTE_LIMIT) begin
              state_next.held_notes = state.held_notes + 6'd1;
            end
          end else if (state.held_notes != 6'd0) begin
            state_next.held_notes = state.held_notes - 6'd1;
          end
        end else if (code <= CODE_CC_BASE) begin
          // Controller key: the controller number is the negated code.
          res.msg_valid   = 1'b1;
          res.status_byte = {ST_CC, ch_nib};
          res.data_one    = 7'(-code);
          res.data_two    = pv;
        end else if (code inside {CODE_ENC_SW_A, CODE_ENC_SW_B}) begin
          res.msg_valid   = 1'b1;
          res.status_byte = {ST_CC, ch_nib};
          res.data_one    = (code == CODE_ENC_SW_A) ? CC_ENC_SW_A : CC_ENC_SW_B;
          res.data_two    = pv;
        end else if (item.key_down && code == CODE_OCT_UP) begin
          if (shift_s < lim_s) begin
            state_next.shift_octaves = state.shift_octaves + 4'sd1;
          end
        end else if (item.key_down && code == CODE_OCT_DOWN) begin
          if (shift_s > -lim_s) begin
            state_next.shift_octaves = state.shift_octaves - 4'sd1;
          end
        end
      end
    end else if (item.encoder_position != last_pos) begin
      // Encoder turn: relative controller change.
      res.msg_valid   = 1'b1;
      res.status_byte = {ST_CC, ch_nib};
      res.data_one    = CC_ENC_TURN + 7'(item.encoder_select);
      res.data_two    = (item.encoder_position > last_pos) ? REL_UP : REL_DOWN;
      if (item.encoder_select) begin
        state_next.enc_pos1 = item.encoder_position;
      end else begin
        state_next.enc_pos0 = item.encoder_position;
      end
    end

    res.octave_shift = state_next.shift_octaves;
    res.active_notes = state_next.held_notes;
  end

endmodule

@@ rtl/key_matrix_to_midi_events_core.sv @@
// ============================================================================
// key_matrix_to_midi_events_core: key matrix and encoders to MIDI events
// Turns key and encoder samples into note, controller and octave events.
// ============================================================================
// Usage:
//   Input items arrive on the s_ group: s_tuser selects a key sample or an
//   encoder sample, s_tdata carries the key position and level and the
//   encoder number and position. Every input item yields exactly one result
//   item on the m_ group; m_tuser flags whether it carries a MIDI message,
//   and m_tdata holds the message bytes, octave shift and held-note count.
//   Registers are written on the cfg_ channel, which is always ready; write
//   them only while no item is in flight.
//   An item is registered in the input register, then in the result register.
//   Throughput: one item per cycle unless m_tready stalls the output, set by
//   the single event stage that reads and updates the key latches and
//   counters in the same cycle, so consecutive items see each other's effects.
//   Reset clears the key latches, octave shift, held-note count, stored
//   encoder positions and the valid flags of both pipeline registers, and
//   restores the registers to channel 1, limit 2 and press value 127.
//   When m_tready is low the result register holds; one more item may wait
//   in the input register, after which s_tready drops.
module key_matrix_to_midi_events_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // key_row[2:0], key_col[5:3], key_down[6],
                                 // encoder_select[7], encoder_position[23:8]
  input  logic [0:0]  s_tuser,   // kind[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // status_byte[7:0], data_one[14:8],
                                 // data_two[21:15], octave_shift[25:22],
                                 // active_notes[31:26]
  output logic [0:0]  m_tuser,   // msg_valid[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import km2midi_pkg::*;

  cfg_t            cfg;
  state_t          state;
  state_t          state_next;
  logic [KEYS-1:0] key_latch;
  logic            in_valid;
  item_t           in_item;
  logic            stage_go;
  result_t         res;
  result_t         out_res;
  latch_upd_t      upd;

  assign cfg_ready = 1'b1;
  assign stage_go  = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || stage_go;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel      <= 5'd1;
      cfg.octave_limit <= 3'd2;
      cfg.press_value  <= 7'd127;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CHANNEL:      cfg.channel      <= cfg_data[4:0];
        CFG_OCTAVE_LIMIT: cfg.octave_limit <= cfg_data[2:0];
        CFG_PRESS_VALUE:  cfg.press_value  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (stage_go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind             <= s_tuser[0];
      in_item.key_row          <= s_tdata[2:0];
      in_item.key_col          <= s_tdata[5:3];
      in_item.key_down         <= s_tdata[6];
      in_item.encoder_select   <= s_tdata[7];
      in_item.encoder_position <= s_tdata[23:8];
    end
  end

  // Event logic between the input and result registers.
  km2midi_event u_event (
    .item       (in_item),
    .cfg        (cfg),
    .state      (state),
    .key_latch  (key_latch),
    .res        (res),
    .state_next (state_next),
    .upd        (upd)
  );

  // Running state and key latches advance with each processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      key_latch <= '0;
    end else if (stage_go) begin
      state <= state_next;
      if (upd.we) begin
        key_latch[upd.idx] <= upd.val;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stage_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go) begin
      out_res <= res;
    end
  end

  assign m_tuser[0] = out_res.msg_valid;
  assign m_tdata    = {out_res.active_notes, out_res.octave_shift, out_res.data_two,
                       out_res.data_one, out_res.status_byte};

endmodule

@@ rtl/km2midi_checker.sv @@
// ============================================================================
// km2midi_checker: port-level checks for the key matrix MIDI block
// Watches the result channel for reset behavior, stall holding and the
// ranges and zero fill of the result fields.
// ============================================================================
module km2midi_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // No result item is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result item holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result item changed");

  // An item without a message carries zero message bytes.
  a_no_msg_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[21:0] == 22'd0)
    else $error("message bytes set without a message");

  // The held-note count never passes its ceiling.
  a_notes_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:26] <= 6'd42)
    else $error("held-note count out of range");

  // The octave shift stays within four octaves either way.
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[25:22]) >= -4'sd4) && ($signed(m_tdata[25:22]) <= 4'sd4))
    else $error("octave shift out of range");

endmodule

bind key_matrix_to_midi_events_core km2midi_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
